[sv/arcade_bus_address_decoder_core_defines.svh]
// Assertion macros shared by the bus address decoder modules.
`ifndef ARCADE_BUS_ADDRESS_DECODER_CORE_DEFINES_SVH
`define ARCADE_BUS_ADDRESS_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/abd_pkg.sv]
// Package with types, constants and address map of the bus address decoder.
`default_nettype none

package abd_pkg;

    // Bus operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DIP_ONE = 1'b0;
    localparam logic CFG_DIP_TWO = 1'b1;

    // Shared byte store geometry.
    localparam int STORE_DEPTH = 5120;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam logic [STORE_IDX_W-1:0] STORE_LAST = STORE_IDX_W'(STORE_DEPTH - 1);

    // Offsets of the video and object RAM windows inside the store.
    localparam logic [STORE_IDX_W-1:0] VRAM_OFFSET = STORE_IDX_W'(12'h800);
    localparam logic [STORE_IDX_W-1:0] ORAM_OFFSET = STORE_IDX_W'(12'hC00);

    // Started flag trigger.
    localparam logic [14:0] STARTED_ADDR      = 15'h5320;
    localparam logic [7:0]  START_IGNORE_DATA = 8'h10;
    localparam logic [7:0]  FETCH_FILL        = 8'hFF;

    // Clearing sequencer states of the store.
    typedef enum logic {
        CLR_SWEEP,
        CLR_RUN
    } clr_state_t;

    // One bus access as it enters the block.
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        coin_button;
        logic        left_button;
        logic        right_button;
        logic        fire_button;
        logic        start_button;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_access;
        logic [13:0] rom_address;
        logic        run_started;
        logic        nmi_enable;
        logic        stars_enable;
        logic [7:0]  vco_pitch;
        logic [3:0]  lfo_bits;
        logic [7:0]  sound_controls;
    } result_t;

    // Region hits of one masked address.
    typedef struct packed {
        logic                   rom_hit;
        logic                   ram_hit;
        logic [STORE_IDX_W-1:0] ram_index;
        logic                   port_one_hit;
        logic                   port_two_hit;
        logic                   port_three_hit;
        logic                   lfo_hit;
        logic                   control_hit;
        logic                   nmi_hit;
        logic                   star_hit;
        logic                   pitch_hit;
        logic                   start_hit;
    } decode_t;

endpackage

`default_nettype wire

[sv/abd_decode.sv]
// Address decoder: maps a masked CPU address onto regions and store indexes.
`default_nettype none

module abd_decode (
    input  wire logic [14:0]    addr,
    input  wire logic [7:0]     data,
    output abd_pkg::decode_t    dec
);
    import abd_pkg::*;

    logic win_work;
    logic win_video;
    logic win_object;

    // RAM windows.
    assign win_work   = (addr[14:11] == 4'b1000);
    assign win_video  = (addr[14:10] == 5'b10100);
    assign win_object = (addr[14:11] == 4'b1011);

    always_comb
    begin
        dec = '0;
        dec.rom_hit    = ~addr[14];
        dec.ram_hit    = win_work | win_video | win_object;
        if (win_work)
        begin
            dec.ram_index = {2'b00, addr[10:0]};
        end
        else if (win_video)
        begin
            dec.ram_index = VRAM_OFFSET + {3'b000, addr[9:0]};
        end
        else
        begin
            dec.ram_index = ORAM_OFFSET + {2'b00, addr[10:0]};
        end

        // Input ports, each mirrored over 2 KiB.
        dec.port_one_hit   = (addr[14:11] == 4'b1100);
        dec.port_two_hit   = (addr[14:11] == 4'b1101);
        dec.port_three_hit = (addr[14:11] == 4'b1110);

        // Write latches.
        dec.lfo_hit     = (addr[14:3] == 12'h C00) & addr[2];
        dec.control_hit = (addr[14:3] == 12'hD00);
        dec.nmi_hit     = (addr[14:3] == 12'hE00) & (addr[2:0] == 3'd1);
        dec.star_hit    = (addr[14:3] == 12'hE00) & (addr[2:0] == 3'd4);
        dec.pitch_hit   = (addr[14:11] == 4'b1111);
        dec.start_hit   = (addr == STARTED_ADDR) & (data != START_IGNORE_DATA);
    end

endmodule

`default_nettype wire

[sv/abd_store.sv]
// Shared byte store for work, video and object RAM with a clearing sweep after reset.
`default_nettype none

module abd_store (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [abd_pkg::STORE_IDX_W-1:0] wr_index,
    input  wire logic [7:0]                      wr_data,
    input  wire logic                            rd_en,
    input  wire logic [abd_pkg::STORE_IDX_W-1:0] rd_index,
    output logic      [7:0]                      rd_data,
    output logic                                 clearing
);
    import abd_pkg::*;

    logic [7:0]             mem [STORE_DEPTH];
    clr_state_t             state_reg;
    clr_state_t             state_next;
    logic [STORE_IDX_W-1:0] clr_idx_reg;
    logic [STORE_IDX_W-1:0] clr_idx_next;
    logic                   mem_we;
    logic [STORE_IDX_W-1:0] mem_widx;
    logic [7:0]             mem_wdata;
    logic [7:0]             rd_data_reg;

    // Sweep sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CLR_SWEEP;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // Sweep next state and write port selection.
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        mem_we       = wr_en;
        mem_widx     = wr_index;
        mem_wdata    = wr_data;
        clearing     = 1'b0;
        case (state_reg)
            CLR_SWEEP:
            begin
                clearing     = 1'b1;
                mem_we       = 1'b1;
                mem_widx     = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == STORE_LAST)
                begin
                    state_next   = CLR_RUN;
                    clr_idx_next = '0;
                end
            end
            CLR_RUN:
            begin
                clearing = 1'b0;
            end
            default:
            begin
                state_next = CLR_SWEEP;
            end
        endcase
    end

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
        end
    end

    assign rd_data = rd_data_reg;

    `include "arcade_bus_address_decoder_core_defines.svh"

    `ABD_ASSERT_NEXT(a_sweep_steps, (state_reg == CLR_SWEEP) && (clr_idx_reg != STORE_LAST), (state_reg == CLR_SWEEP) && (clr_idx_reg == $past(clr_idx_reg) + 1'b1), "clear sweep skipped an entry")
    `ABD_ASSERT_NEXT(a_sweep_ends, (state_reg == CLR_SWEEP) && (clr_idx_reg == STORE_LAST), state_reg == CLR_RUN, "clear sweep did not finish")
    `ABD_ASSERT_NEXT(a_sweep_once, state_reg == CLR_RUN, state_reg == CLR_RUN, "clear sweep restarted without reset")

endmodule

`default_nettype wire

[sv/arcade_bus_address_decoder_core.sv]
// Top level of the arcade bus address decoder.
`default_nettype none

// Decodes one CPU bus access per clock cycle. An access is taken when start is
// high and busy is low; its result word appears on result with result_valid high
// for exactly one cycle, one cycle after the access was taken, and the receiver
// must capture it then. The shared byte store has a registered read port; a new
// access can be taken in every cycle with busy low. After reset, busy stays high
// while all 5120 store entries are swept to zero; configuration writes are taken
// at any time, including during that sweep. The latch outputs in each result
// reflect the state after that access.
module arcade_bus_address_decoder_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire abd_pkg::item_t   item,
    output logic                  result_valid,
    output abd_pkg::result_t      result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [7:0]       cfg_data
);
    import abd_pkg::*;

    logic        accepted;
    logic [14:0] addr;
    decode_t     dec;
    logic        is_read;
    logic        is_write;
    logic        is_fetch;
    logic        clearing;
    logic        store_rd_en;
    logic        store_wr_en;
    logic [7:0]  store_q;
    logic [7:0]  port_byte;

    logic        valid_reg;
    logic        use_ram_reg;
    logic [7:0]  rd_reg;
    logic [7:0]  rd_next;
    logic        rom_reg;
    logic [13:0] rom_addr_reg;
    logic        started_reg;
    logic        started_next;
    logic        nmi_reg;
    logic        nmi_next;
    logic        star_reg;
    logic        star_next;
    logic [7:0]  pitch_reg;
    logic [7:0]  pitch_next;
    logic [3:0]  lfo_reg;
    logic [3:0]  lfo_next;
    logic [7:0]  control_reg;
    logic [7:0]  control_next;
    logic [7:0]  dip_one_reg;
    logic [7:0]  dip_two_reg;

    // Handshake and operation decode.
    assign busy      = clearing;
    assign accepted  = start & ~clearing;
    assign addr      = item.bus_address[14:0];
    assign is_read   = (item.operation == OP_READ);
    assign is_write  = (item.operation == OP_WRITE);
    assign is_fetch  = (item.operation == OP_FETCH);
    assign cfg_ready = 1'b1;

    abd_decode u_decode (
        .addr (addr),
        .data (item.write_data),
        .dec  (dec)
    );

    // Store accesses: reads of RAM windows and writes to them.
    assign store_rd_en = accepted & is_read & ~dec.rom_hit & dec.ram_hit;
    assign store_wr_en = accepted & is_write & dec.ram_hit;

    abd_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (store_wr_en),
        .wr_index (dec.ram_index),
        .wr_data  (item.write_data),
        .rd_en    (store_rd_en),
        .rd_index (dec.ram_index),
        .rd_data  (store_q),
        .clearing (clearing)
    );

    // Input port bytes for reads outside the store.
    always_comb
    begin
        port_byte = '0;
        if (dec.port_one_hit)
        begin
            port_byte = {3'b000, item.fire_button, item.right_button,
                         item.left_button, 1'b0, item.coin_button};
        end
        else if (dec.port_two_hit)
        begin
            port_byte = dip_one_reg | {7'b0000000, item.start_button};
        end
        else if (dec.port_three_hit)
        begin
            port_byte = dip_two_reg;
        end
    end

    // Read data that does not come from the store.
    always_comb
    begin
        rd_next = '0;
        if (is_fetch && !dec.rom_hit)
        begin
            rd_next = FETCH_FILL;
        end
        else if (is_read && !dec.rom_hit && !dec.ram_hit)
        begin
            rd_next = port_byte;
        end
    end

    // Next values of the write latches.
    always_comb
    begin
        started_next = started_reg;
        nmi_next     = nmi_reg;
        star_next    = star_reg;
        pitch_next   = pitch_reg;
        lfo_next     = lfo_reg;
        control_next = control_reg;
        if (accepted && is_write)
        begin
            if (dec.start_hit)
            begin
                started_next = 1'b1;
            end
            if (dec.lfo_hit)
            begin
                lfo_next[addr[1:0]] = item.write_data[0];
            end
            if (dec.control_hit)
            begin
                control_next[addr[2:0]] = item.write_data[0];
            end
            if (dec.nmi_hit)
            begin
                nmi_next = item.write_data[0];
            end
            if (dec.star_hit)
            begin
                star_next = item.write_data[0];
            end
            if (dec.pitch_hit)
            begin
                pitch_next = item.write_data;
            end
        end
    end

    // Control state and latches.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
            nmi_reg     <= 1'b0;
            star_reg    <= 1'b0;
            pitch_reg   <= '0;
            lfo_reg     <= '0;
            control_reg <= '0;
            dip_one_reg <= '0;
            dip_two_reg <= '0;
        end
        else
        begin
            valid_reg   <= accepted;
            started_reg <= started_next;
            nmi_reg     <= nmi_next;
            star_reg    <= star_next;
            pitch_reg   <= pitch_next;
            lfo_reg     <= lfo_next;
            control_reg <= control_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIP_ONE: dip_one_reg <= cfg_data;
                    CFG_DIP_TWO: dip_two_reg <= cfg_data;
                    default:     dip_one_reg <= dip_one_reg;
                endcase
            end
        end
    end

    // Result payload captured with the access.
    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            use_ram_reg  <= store_rd_en;
            rd_reg       <= rd_next;
            rom_reg      <= (is_read | is_fetch) & dec.rom_hit;
            rom_addr_reg <= ((is_read | is_fetch) & dec.rom_hit) ? addr[13:0] : 14'd0;
        end
    end

    // Result word.
    always_comb
    begin
        result                = '0;
        result.read_data      = use_ram_reg ? store_q : rd_reg;
        result.rom_access     = rom_reg;
        result.rom_address    = rom_addr_reg;
        result.run_started    = started_reg;
        result.nmi_enable     = nmi_reg;
        result.stars_enable   = star_reg;
        result.vco_pitch      = pitch_reg;
        result.lfo_bits       = lfo_reg;
        result.sound_controls = control_reg;
    end

    assign result_valid = valid_reg;

    `include "arcade_bus_address_decoder_core_defines.svh"

    `ABD_ASSERT_NEXT(a_one_result, accepted, result_valid, "accepted access gave no result")
    `ABD_ASSERT_NEXT(a_no_spurious, !accepted, !result_valid, "result without an access")
    `ABD_ASSERT_NOW(a_rom_zero, result_valid && result.rom_access, result.read_data == 8'h00, "ROM access returned nonzero data")
    `ABD_ASSERT_NOW(a_no_rom_addr, result_valid && !result.rom_access, result.rom_address == 14'd0, "ROM offset without ROM access")
    `ABD_ASSERT_NEXT(a_started_sticky, started_reg, started_reg, "started flag cleared")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the arcade bus address decoder core.
`timescale 1ns / 1ps

module tb_top;
    import abd_pkg::*;

    // Operation code that the bus never issues; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycles without any handshake or result before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 20000;
    // Accesses per random traffic phase.
    localparam int PHASE_ACCESSES = 667;

    // Memory map model of the block: decodes each accepted access, keeps its own
    // copy of the byte store and latches, and checks result words in order.
    class bus_map_model;
        logic [7:0] ram_bytes [STORE_DEPTH];
        logic       started;
        logic       nmi_on;
        logic       stars_on;
        logic [7:0] pitch;
        logic [3:0] lfo;
        logic [7:0] controls;
        logic [7:0] dip_one;
        logic [7:0] dip_two;
        result_t    expected_words [$];
        int         errors;
        int         checked;
        int         n_read;
        int         n_write;
        int         n_fetch;
        int         n_other;

        function new();
            foreach (ram_bytes[i])
                ram_bytes[i] = 8'h00;
            started  = 1'b0;
            nmi_on   = 1'b0;
            stars_on = 1'b0;
            pitch    = 8'h00;
            lfo      = 4'h0;
            controls = 8'h00;
            dip_one  = 8'h00;
            dip_two  = 8'h00;
            errors   = 0;
            checked  = 0;
            n_read   = 0;
            n_write  = 0;
            n_fetch  = 0;
            n_other  = 0;
        endfunction

        function void set_dip(logic idx, logic [7:0] val);
            if (idx == CFG_DIP_ONE)
                dip_one = val;
            else
                dip_two = val;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Store slot of a masked address, or -1 outside the three RAM windows.
        function int store_slot(logic [14:0] a);
            if ((a & 15'h7800) == 15'h4000)
                return int'(a[10:0]);
            if ((a & 15'h7C00) == 15'h5000)
                return int'(VRAM_OFFSET) + int'(a[9:0]);
            if ((a & 15'h7800) == 15'h5800)
                return int'(ORAM_OFFSET) + int'(a[10:0]);
            return -1;
        endfunction

        // Data read of a non-ROM address: store, input ports or zero.
        function logic [7:0] data_read(item_t it, logic [14:0] a);
            int slot;
            slot = store_slot(a);
            if (slot >= 0)
                return ram_bytes[slot];
            if ((a & 15'h7800) == 15'h6000)
                return {3'b000, it.fire_button, it.right_button, it.left_button,
                        1'b0, it.coin_button};
            if ((a & 15'h7800) == 15'h6800)
                return dip_one | {7'b0, it.start_button};
            if ((a & 15'h7800) == 15'h7000)
                return dip_two;
            return 8'h00;
        endfunction

        // Data write: store first, then the latch groups; anything else is dropped.
        function void data_write(logic [14:0] a, logic [7:0] d);
            int slot;
            slot = store_slot(a);
            if (slot >= 0) begin
                if (a == STARTED_ADDR && d != START_IGNORE_DATA)
                    started = 1'b1;
                ram_bytes[slot] = d;
            end
            else if ((a & 15'h7FF8) == 15'h6000) begin
                if (a >= 15'h6004)
                    lfo[a[1:0]] = d[0];
            end
            else if ((a & 15'h7FF8) == 15'h6800)
                controls[a[2:0]] = d[0];
            else if ((a & 15'h7FF8) == 15'h7000) begin
                if (a[2:0] == 3'd1)
                    nmi_on = d[0];
                if (a[2:0] == 3'd4)
                    stars_on = d[0];
            end
            else if ((a & 15'h7800) == 15'h7800)
                pitch = d;
        endfunction

        // Works out the result word of one accepted access and queues it.
        function void note_access(item_t it);
            result_t    word;
            logic [14:0] a;
            a = it.bus_address[14:0];
            word = '0;
            if (it.operation == OP_READ || it.operation == OP_FETCH) begin
                if (it.operation == OP_READ)
                    n_read++;
                else
                    n_fetch++;
                if (a < 15'h4000) begin
                    word.rom_access  = 1'b1;
                    word.rom_address = a[13:0];
                end
                else if (it.operation == OP_FETCH)
                    word.read_data = FETCH_FILL;
                else
                    word.read_data = data_read(it, a);
            end
            else if (it.operation == OP_WRITE) begin
                n_write++;
                data_write(a, it.write_data);
            end
            else
                n_other++;
            word.run_started    = started;
            word.nmi_enable     = nmi_on;
            word.stars_enable   = stars_on;
            word.vco_pitch      = pitch;
            word.lfo_bits       = lfo;
            word.sound_controls = controls;
            expected_words.push_back(word);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR: %s", msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %0d field %s: got 0x%0h expected 0x%0h",
                                          checked, name, got, want));
        endtask

        // Checks one result word against the oldest expectation.
        task check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word 0x%0h with nothing expected", got));
                return;
            end
            want = expected_words.pop_front();
            compare_field("read_data", got.read_data, want.read_data);
            compare_field("rom_access", got.rom_access, want.rom_access);
            compare_field("rom_address", got.rom_address, want.rom_address);
            compare_field("run_started", got.run_started, want.run_started);
            compare_field("nmi_enable", got.nmi_enable, want.nmi_enable);
            compare_field("stars_enable", got.stars_enable, want.stars_enable);
            compare_field("vco_pitch", got.vco_pitch, want.vco_pitch);
            compare_field("lfo_bits", got.lfo_bits, want.lfo_bits);
            compare_field("sound_controls", got.sound_controls, want.sound_controls);
            checked++;
        endtask

        task finish_check();
            if (expected_words.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived",
                                          expected_words.size()));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    item_t      item_word = '0;
    logic       result_valid;
    result_t    result_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_DIP_ONE;
    logic [7:0] cfg_data = 8'h00;

    bus_map_model map_model = new();
    int           sender_idle_pct = 0;
    int           quiet_cycles = 0;

    arcade_bus_address_decoder_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item_word),
        .result_valid (result_valid),
        .result       (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Result words are sampled at the edge that ends their cycle.
    always @(posedge clk) begin
        if (rst_n && result_valid)
            map_model.check_word(result_word);
    end

    // Watchdog on cycles in which nothing moves on any channel.
    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic item_t make_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                                        logic [4:0] btn);
        item_t it;
        it.operation    = op;
        it.bus_address  = addr;
        it.write_data   = data;
        it.coin_button  = btn[4];
        it.left_button  = btn[3];
        it.right_button = btn[2];
        it.fire_button  = btn[1];
        it.start_button = btn[0];
        return it;
    endfunction

    // Random access aimed at the mapped regions, with a hot set of store
    // addresses so that reads often land on recently written bytes.
    function automatic item_t random_access();
        item_t       it;
        int          pick;
        int          win;
        logic [14:0] a;
        it.write_data   = 8'($urandom_range(255));
        it.coin_button  = 1'($urandom_range(1));
        it.left_button  = 1'($urandom_range(1));
        it.right_button = 1'($urandom_range(1));
        it.fire_button  = 1'($urandom_range(1));
        it.start_button = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 40)
            it.operation = OP_READ;
        else if (pick < 75)
            it.operation = OP_WRITE;
        else if (pick < 95)
            it.operation = OP_FETCH;
        else
            it.operation = OP_UNUSED;
        pick = $urandom_range(99);
        if (pick < 15)
            a = 15'($urandom_range(16'h3FFF));
        else if (pick < 45) begin
            win = $urandom_range(2);
            if (win == 0)
                a = 15'h4000;
            else if (win == 1)
                a = 15'h5000;
            else
                a = 15'h5800;
            if ($urandom_range(9) < 7)
                a = a + 15'($urandom_range(15));
            else
                a = a + 15'($urandom_range(win == 1 ? 16'h3FF : 16'h7FF));
        end
        else if (pick < 55)
            a = 15'h6000 + 15'($urandom_range(16'h17FF));
        else if (pick < 70) begin
            win = $urandom_range(2);
            a = (win == 0) ? 15'h6000 : (win == 1) ? 15'h6800 : 15'h7000;
            a = a + 15'($urandom_range(7));
        end
        else if (pick < 75)
            a = 15'h7800 + 15'($urandom_range(16'h7FF));
        else if (pick < 80) begin
            a = STARTED_ADDR;
            if ($urandom_range(1) == 1)
                it.write_data = START_IGNORE_DATA;
        end
        else
            a = 15'($urandom_range(16'h7FFF));
        it.bus_address = {1'($urandom_range(1)), a};
        return it;
    endfunction

    // Presents one access and holds it until the block takes it; then maybe idles.
    task automatic send_access(item_t it);
        start     <= 1'b1;
        item_word <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        map_model.note_access(it);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Writes both DIP registers back to back over the configuration channel.
    task automatic set_dips(logic [7:0] one, logic [7:0] two);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DIP_ONE;
        cfg_data  <= one;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        map_model.set_dip(CFG_DIP_ONE, one);
        cfg_index <= CFG_DIP_TWO;
        cfg_data  <= two;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        map_model.set_dip(CFG_DIP_TWO, two);
        cfg_valid <= 1'b0;
    endtask

    // Stops issuing accesses and waits until every result word has come back.
    task automatic drain();
        start <= 1'b0;
        while (map_model.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial begin
        int     counted;
        int     phase;
        item_t  it;
        int     idle_by_phase [3];

        idle_by_phase = '{23, 72, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, back to back so that a read follows its write directly.
        set_dips(8'h00, 8'hFF);
        send_access(make_item(OP_READ,  16'h0000, 8'h00, 5'b00000));
        send_access(make_item(OP_FETCH, 16'h3FFF, 8'hFF, 5'b11111));
        send_access(make_item(OP_READ,  16'hBFFF, 8'h00, 5'b00000));
        send_access(make_item(OP_FETCH, 16'h4000, 8'h00, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h4000, 8'hFF, 5'b00000));
        send_access(make_item(OP_READ,  16'h4000, 8'h00, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h47FF, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h5000, 8'h80, 5'b00000));
        send_access(make_item(OP_WRITE, 16'hD3FF, 8'h7E, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h5FFF, 8'hAA, 5'b00000));
        send_access(make_item(OP_READ,  16'h5FFF, 8'h00, 5'b00000));
        send_access(make_item(OP_READ,  16'h53FF, 8'h00, 5'b00000));
        send_access(make_item(OP_READ,  16'h4800, 8'h00, 5'b11111));
        send_access(make_item(OP_READ,  16'h5400, 8'h00, 5'b11111));
        send_access(make_item(OP_READ,  16'h7800, 8'h00, 5'b11111));
        // The started flag ignores the one reserved data byte, then sticks.
        send_access(make_item(OP_WRITE, 16'h5320, START_IGNORE_DATA, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h5320, 8'h00, 5'b00000));
        send_access(make_item(OP_READ,  16'h6000, 8'h00, 5'b11111));
        send_access(make_item(OP_READ,  16'h6800, 8'h00, 5'b00001));
        send_access(make_item(OP_READ,  16'h7000, 8'h00, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h6004, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h6007, 8'hFF, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h6003, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h6807, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h6808, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h7001, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h7004, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h7002, 8'h01, 5'b00000));
        send_access(make_item(OP_WRITE, 16'hFFFF, 8'hC3, 5'b00000));
        send_access(make_item(OP_WRITE, 16'h0100, 8'h5A, 5'b00000));
        send_access(make_item(OP_UNUSED, 16'h4000, 8'h12, 5'b11111));

        // Random traffic in three phases of sender idling, each with new DIP bytes.
        for (phase = 0; phase < 3; phase++) begin
            drain();
            if (phase == 0)
                set_dips(8'hFF, 8'h00);
            else
                set_dips(8'($urandom_range(255)), 8'($urandom_range(255)));
            sender_idle_pct = idle_by_phase[phase];
            counted = 0;
            while (counted < PHASE_ACCESSES) begin
                it = random_access();
                send_access(it);
                if (it.operation != OP_UNUSED)
                    counted++;
            end
        end

        drain();
        repeat (4) @(posedge clk);
        map_model.finish_check();

        $display("Checked %0d result words: %0d reads, %0d writes, %0d fetches, %0d unused ops.",
                 map_model.checked, map_model.n_read, map_model.n_write, map_model.n_fetch,
                 map_model.n_other);
        $display("Traffic ran with sender gaps of 23, 72 and 0 percent under four DIP settings.");
        if (map_model.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
